[rtl/fcs_pkg.sv]
// Shared types and constants of the FOC transform and SVPWM chain.
package fcs_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int XW = 34;                 // CORDIC x/y width, Q2.30 plus growth
	localparam int ZW = 33;                 // CORDIC angle accumulator width
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
	localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
	localparam logic [15:0] HALF_SQRT3_Q16 = 16'd56756;
	localparam logic [15:0] DUTY_MID = 16'd32768;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// voltage path widths
	localparam int AW = 23;                 // doubled phase voltages
	localparam int UW = AW + 2;             // phase plus zero sequence
	localparam int DW = UW + 15;            // divider dividend and quotient

	// request fields that ride along the CORDIC pipeline
	typedef struct packed {
		logic signed [15:0] ia;
		logic signed [16:0] ibeta;
		logic signed [15:0] vd;
		logic signed [15:0] vq;
		logic [15:0]        bus;
		logic [1:0]         quad;
	} fcs_side_t;

	// fields that ride along the divider pipeline
	typedef struct packed {
		logic [2:0]         neg;
		logic signed [15:0] cur_d;
		logic signed [15:0] cur_q;
	} fcs_tail_t;

endpackage

[rtl/fcs_cordic.sv]
// Pipelined rotation-mode CORDIC, one iteration per stage.
module fcs_cordic import fcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [ZW-1:0] z_in,
	input  fcs_side_t            side_in,
	output logic                 out_valid,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output fcs_side_t            side_out
);

	logic [CORDIC_STEPS-1:0] v_s;
	logic signed [XW-1:0] x_s [CORDIC_STEPS];
	logic signed [XW-1:0] y_s [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS];
	fcs_side_t            sd_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic signed [XW-1:0] xp, yp;
		logic signed [ZW-1:0] zp;
		logic                 vp;
		fcs_side_t            sp;

		if (i == 0) begin : g_first
			assign xp = XW'(CORDIC_GAIN);
			assign yp = '0;
			assign zp = z_in;
			assign vp = in_valid;
			assign sp = side_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
			assign sp = sd_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else v_s[i] <= vp;
		end

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (zp[ZW-1]) begin
				x_s[i] <= xp + (yp >>> i);
				y_s[i] <= yp - (xp >>> i);
				z_s[i] <= zp + $signed({1'b0, ATAN_TURNS[i]});
			end else begin
				x_s[i] <= xp - (yp >>> i);
				y_s[i] <= yp + (xp >>> i);
				z_s[i] <= zp - $signed({1'b0, ATAN_TURNS[i]});
			end
			sd_s[i] <= sp;
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign x_out     = x_s[CORDIC_STEPS-1];
	assign y_out     = y_s[CORDIC_STEPS-1];
	assign side_out  = sd_s[CORDIC_STEPS-1];

endmodule

[rtl/fcs_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
module fcs_div import fcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [15:0]         bus_in,
	input  logic [2:0][DW-1:0]  num_in,
	input  fcs_tail_t           tail_in,
	output logic                out_valid,
	output logic [2:0][DW-1:0]  quot_out,
	output fcs_tail_t           tail_out
);

	logic [DW-1:0]       v_s;
	logic [15:0]         bus_s [DW];
	logic [2:0][15:0]    rem_s [DW];
	logic [2:0][DW-1:0]  dq_s  [DW];
	fcs_tail_t           tl_s  [DW];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [15:0]        busp;
		logic [2:0][15:0]   remp, remn;
		logic [2:0][DW-1:0] dqp, dqn;
		logic               vp;
		fcs_tail_t          tp;

		if (i == 0) begin : g_first
			assign busp = bus_in;
			assign remp = '0;
			assign dqp  = num_in;
			assign vp   = in_valid;
			assign tp   = tail_in;
		end else begin : g_next
			assign busp = bus_s[i-1];
			assign remp = rem_s[i-1];
			assign dqp  = dq_s[i-1];
			assign vp   = v_s[i-1];
			assign tp   = tl_s[i-1];
		end

		always_comb begin
			logic [16:0] t;
			logic        ge;
			remn = '0;
			dqn  = '0;
			for (int k = 0; k < 3; k++) begin
				t  = {remp[k], dqp[k][DW-1]};
				ge = (t >= {1'b0, busp});
				remn[k] = ge ? 16'(t - {1'b0, busp}) : t[15:0];
				dqn[k]  = {dqp[k][DW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else v_s[i] <= vp;
		end

		always_ff @(posedge clk) begin
			bus_s[i] <= busp;
			rem_s[i] <= remn;
			dq_s[i]  <= dqn;
			tl_s[i]  <= tp;
		end
	end

	assign out_valid = v_s[DW-1];
	assign quot_out  = dq_s[DW-1];
	assign tail_out  = tl_s[DW-1];

endmodule

[rtl/foc_transform_svpwm_chain.sv]
// Top level: Clarke/Park current transform and inverse Park/Clarke SVPWM duty chain.
//
// Fully pipelined FOC transform chain. A request is taken on every clock edge with
// start high (busy is always low). Its result appears on the output ports with done
// high once the request has passed through every stage of the pipe. That is 79
// register stages in all: one input register that loads on the accepting edge, 30
// CORDIC stages for sine and cosine, and seven arithmetic stages (trig rounding,
// products, sums, sqrt(3)/2 product, phase voltages, min-max injection, dividend).
// Then come 40 divider stages (one quotient bit each, which sets the depth) and the
// output register. Results stream out at one per cycle and cannot be held off, so
// capture each one while done is high. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and are read live by the pipeline, so write them only
// while no request is in flight.
module foc_transform_svpwm_chain import fcs_pkg::*; #(
	parameter int ANGLE_BITS  = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] phase_a_current,
	input  logic signed [15:0] phase_b_current,
	input  logic [15:0]        rotor_angle,
	input  logic signed [15:0] volt_d,
	input  logic signed [15:0] volt_q,
	input  logic [15:0]        bus_voltage,
	output logic signed [15:0] current_d,
	output logic signed [15:0] current_q,
	output logic [15:0]        duty_a,
	output logic [15:0]        duty_b,
	output logic [15:0]        duty_c
);

	localparam int TF = SAMPLE_BITS - 2;            // trig fraction bits
	localparam int TW = SAMPLE_BITS;                // trig word width
	localparam int SH = 30 - TF;                    // CORDIC to trig rounding shift
	localparam int PW = 17 + TW;                    // product width
	localparam int SW = PW + 1;                     // sum of products
	localparam int RW = SW - TF;                    // rounded sum width
	localparam int HW = RW + 17;                    // sqrt(3)/2 product width
	localparam logic [15:0] ANG_MASK = 16'(~((32'd1 << (16 - ANGLE_BITS)) - 32'd1));
	localparam logic signed [XW:0] TRIG_HALF = (XW+1)'((64'd1 << SH) >> 1);
	localparam logic signed [SW-1:0] SUM_HALF = SW'(64'd1 << (TF - 1));

	localparam logic [1:0] REG_BUS_MIN  = 2'd0;
	localparam logic [1:0] REG_BUS_FB   = 2'd1;
	localparam logic [1:0] REG_FLOOR    = 2'd2;
	localparam logic [1:0] REG_CEILING  = 2'd3;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---------------- configuration registers ----------------
	logic [15:0] bus_min_q, bus_fb_q, floor_q, ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_min_q <= 16'd256;
			bus_fb_q  <= 16'd3072;
			floor_q   <= 16'd3277;
			ceil_q    <= 16'd62259;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUS_MIN: bus_min_q <= cfg_data;
				REG_BUS_FB:  bus_fb_q  <= cfg_data;
				REG_FLOOR:   floor_q   <= cfg_data;
				REG_CEILING: ceil_q    <= cfg_data;
			endcase
		end
	end

	// ---------------- stage 1: capture request ----------------
	logic               v_s1;
	logic signed [15:0] ia_s1, ib_s1, vd_s1, vq_s1;
	logic [15:0]        ang_s1, bus_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		ia_s1  <= phase_a_current;
		ib_s1  <= phase_b_current;
		ang_s1 <= rotor_angle & ANG_MASK;
		vd_s1  <= volt_d;
		vq_s1  <= volt_q;
		bus_s1 <= bus_voltage;
	end

	// quadrant fold, Clarke beta and bus selection feed the CORDIC pipe
	logic [31:0]          ang32, rem32;
	logic [1:0]           quad;
	logic signed [ZW-1:0] z0;
	logic signed [17:0]   ab_sum;
	logic signed [34:0]   ab_prod;
	logic signed [34:0]   ab_rnd;
	logic [15:0]          bus_sel;
	fcs_side_t            side0;

	always_comb begin
		ang32   = {ang_s1, 16'h0000};
		quad    = 2'((ang32 + 32'h2000_0000) >> 30);
		rem32   = ang32 - {quad, 30'h0};
		z0      = $signed({rem32[31], rem32});
		ab_sum  = 18'(ia_s1) + (18'(ib_s1) <<< 1);
		ab_prod = 35'(ab_sum) * $signed({19'd0, INV_SQRT3_Q16});
		ab_rnd  = (ab_prod + 35'sd32768) >>> 16;
		bus_sel = (bus_s1 < bus_min_q) ? bus_fb_q : bus_s1;
		if (bus_sel == 16'd0) bus_sel = 16'd1;
		side0.ia    = ia_s1;
		side0.ibeta = ab_rnd[16:0];
		side0.vd    = vd_s1;
		side0.vq    = vq_s1;
		side0.bus   = bus_sel;
		side0.quad  = quad;
	end

	logic                 cv;
	logic signed [XW-1:0] cx, cy;
	fcs_side_t            cside;

	fcs_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.z_in      (z0),
		.side_in   (side0),
		.out_valid (cv),
		.x_out     (cx),
		.y_out     (cy),
		.side_out  (cside)
	);

	// ---------------- stage 2: unfold quadrant, round trig ----------------
	logic signed [XW-1:0] cm, sm;
	logic signed [XW:0]   c_rnd, s_rnd;
	logic                 v_s2;
	logic signed [TW-1:0] c_s2, s_s2;
	fcs_side_t            sd_s2;

	always_comb begin
		unique case (cside.quad)
			QUAD_0: begin cm = cx;  sm = cy;  end
			QUAD_1: begin cm = -cy; sm = cx;  end
			QUAD_2: begin cm = -cx; sm = -cy; end
			QUAD_3: begin cm = cy;  sm = -cx; end
		endcase
		c_rnd = ((XW+1)'(cm) + TRIG_HALF) >>> SH;
		s_rnd = ((XW+1)'(sm) + TRIG_HALF) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= cv;
	end

	always_ff @(posedge clk) begin
		c_s2  <= c_rnd[TW-1:0];
		s_s2  <= s_rnd[TW-1:0];
		sd_s2 <= cside;
	end

	// ---------------- stage 3: rotation products ----------------
	logic                 v_s3;
	logic signed [PW-1:0] p_ac_s3, p_bs_s3, p_bc_s3, p_as_s3;
	logic signed [PW-1:0] p_dc_s3, p_qs_s3, p_ds_s3, p_qc_s3;
	logic [15:0]          bus_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		p_ac_s3 <= PW'(PW'(sd_s2.ia) * PW'(c_s2));
		p_as_s3 <= PW'(PW'(sd_s2.ia) * PW'(s_s2));
		p_bc_s3 <= PW'(PW'(sd_s2.ibeta) * PW'(c_s2));
		p_bs_s3 <= PW'(PW'(sd_s2.ibeta) * PW'(s_s2));
		p_dc_s3 <= PW'(PW'(sd_s2.vd) * PW'(c_s2));
		p_ds_s3 <= PW'(PW'(sd_s2.vd) * PW'(s_s2));
		p_qc_s3 <= PW'(PW'(sd_s2.vq) * PW'(c_s2));
		p_qs_s3 <= PW'(PW'(sd_s2.vq) * PW'(s_s2));
		bus_s3  <= sd_s2.bus;
	end

	// ---------------- stage 4: Park sums, rounding, saturation ----------------
	logic signed [SW-1:0] sum_d, sum_q, sum_a, sum_b;
	logic signed [SW-1:0] rd, rq, ra, rb;
	logic                 v_s4;
	logic signed [15:0]   id_s4, iq_s4;
	logic signed [RW-1:0] valpha_s4, vbeta_s4;
	logic [15:0]          bus_s4;

	function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
		if (v > RW'(32767)) return 16'sh7FFF;
		if (v < -RW'(32768)) return -16'sh8000;
		return v[15:0];
	endfunction

	always_comb begin
		sum_d = SW'(p_ac_s3) + SW'(p_bs_s3);
		sum_q = SW'(p_bc_s3) - SW'(p_as_s3);
		sum_a = SW'(p_dc_s3) - SW'(p_qs_s3);
		sum_b = SW'(p_ds_s3) + SW'(p_qc_s3);
		rd = (sum_d + SUM_HALF) >>> TF;
		rq = (sum_q + SUM_HALF) >>> TF;
		ra = (sum_a + SUM_HALF) >>> TF;
		rb = (sum_b + SUM_HALF) >>> TF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		id_s4     <= sat16(rd[RW-1:0]);
		iq_s4     <= sat16(rq[RW-1:0]);
		valpha_s4 <= ra[RW-1:0];
		vbeta_s4  <= rb[RW-1:0];
		bus_s4    <= bus_s3;
	end

	// ---------------- stage 5: sqrt(3)/2 product ----------------
	logic                 v_s5;
	logic signed [HW-1:0] hp_s5;
	logic signed [RW-1:0] valpha_s5;
	logic signed [15:0]   id_s5, iq_s5;
	logic [15:0]          bus_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		hp_s5     <= HW'(HW'(vbeta_s4) * $signed({{(HW-16){1'b0}}, HALF_SQRT3_Q16}));
		valpha_s5 <= valpha_s4;
		id_s5     <= id_s4;
		iq_s5     <= iq_s4;
		bus_s5    <= bus_s4;
	end

	// ---------------- stage 6: doubled phase voltages ----------------
	logic signed [HW-1:0] h_full;
	logic signed [AW-1:0] h2, va;
	logic                 v_s6;
	logic signed [AW-1:0] a2_s6, b2_s6, c2_s6;
	logic signed [15:0]   id_s6, iq_s6;
	logic [15:0]          bus_s6;

	always_comb begin
		h_full = (hp_s5 + HW'(32768)) >>> 16;
		h2     = AW'(h_full) <<< 1;
		va     = AW'(valpha_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		a2_s6  <= va <<< 1;
		b2_s6  <= h2 - va;
		c2_s6  <= -va - h2;
		id_s6  <= id_s5;
		iq_s6  <= iq_s5;
		bus_s6 <= bus_s5;
	end

	// ---------------- stage 7: min-max zero-sequence injection ----------------
	logic signed [AW-1:0] mx, mn;
	logic signed [UW-1:0] mm;
	logic                 v_s7;
	logic signed [UW-1:0] ua_s7, ub_s7, uc_s7;
	logic signed [15:0]   id_s7, iq_s7;
	logic [15:0]          bus_s7;

	always_comb begin
		mx = a2_s6;
		mn = a2_s6;
		if (b2_s6 > mx) mx = b2_s6;
		if (b2_s6 < mn) mn = b2_s6;
		if (c2_s6 > mx) mx = c2_s6;
		if (c2_s6 < mn) mn = c2_s6;
		mm = UW'(mx) + UW'(mn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		ua_s7  <= (UW'(a2_s6) <<< 1) - mm;
		ub_s7  <= (UW'(b2_s6) <<< 1) - mm;
		uc_s7  <= (UW'(c2_s6) <<< 1) - mm;
		id_s7  <= id_s6;
		iq_s7  <= iq_s6;
		bus_s7 <= bus_s6;
	end

	// ---------------- stage 8: sign and rounded dividend ----------------
	logic signed [UW-1:0] u_lane [3];
	logic [2:0][DW-1:0]   num;
	logic [2:0]           neg;
	logic                 v_s8;
	logic [2:0][DW-1:0]   num_s8;
	fcs_tail_t            tail_s8;
	logic [15:0]          bus_s8;

	always_comb begin
		logic [UW-1:0] mag;
		u_lane[0] = ua_s7;
		u_lane[1] = ub_s7;
		u_lane[2] = uc_s7;
		for (int k = 0; k < 3; k++) begin
			neg[k] = u_lane[k][UW-1];
			mag    = neg[k] ? UW'(-u_lane[k]) : UW'(u_lane[k]);
			num[k] = (DW'(mag) << 14) + DW'(bus_s7 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		num_s8        <= num;
		tail_s8.neg   <= neg;
		tail_s8.cur_d <= id_s7;
		tail_s8.cur_q <= iq_s7;
		bus_s8        <= bus_s7;
	end

	// ---------------- divider pipe ----------------
	logic               dv;
	logic [2:0][DW-1:0] quot;
	fcs_tail_t          dtail;

	fcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.bus_in    (bus_s8),
		.num_in    (num_s8),
		.tail_in   (tail_s8),
		.out_valid (dv),
		.quot_out  (quot),
		.tail_out  (dtail)
	);

	// ---------------- output stage: recenter and clamp ----------------
	logic [15:0] duty [3];

	always_comb begin
		logic signed [DW+1:0] d;
		for (int k = 0; k < 3; k++) begin
			d = dtail.neg[k] ? ((DW+2)'(DUTY_MID) - (DW+2)'(quot[k]))
			                 : ((DW+2)'(DUTY_MID) + (DW+2)'(quot[k]));
			priority if (d > $signed((DW+2)'(ceil_q))) duty[k] = ceil_q;
			else if (d < $signed((DW+2)'(floor_q))) duty[k] = floor_q;
			else duty[k] = d[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv;
	end

	// hold results on the ports; done marks the single valid cycle
	always_ff @(posedge clk) begin
		current_d <= dtail.cur_d;
		current_q <= dtail.cur_q;
		duty_a    <= duty[0];
		duty_b    <= duty[1];
		duty_c    <= duty[2];
	end

endmodule

[rtl/fcs_check.sv]
// Port-level checker for the FOC transform chain and its bind.
module fcs_check #(
	parameter int LAT = 79
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request without result after fixed latency");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching request");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("pipeline refused a request");

endmodule

bind foc_transform_svpwm_chain fcs_check u_fcs_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

[bench/tb_top.sv]
// Testbench for the FOC transform and SVPWM duty chain: predicts and checks every result.
`timescale 1ns / 100ps

module tb_top;
	import fcs_pkg::*;

	localparam int LATENCY    = 79;
	localparam int STALL_MAX  = 4000;   // idle cycles before the watchdog trips
	localparam int N_RANDOM   = 530;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_BUS_MIN_VALID = 2'd0,
		REG_BUS_FALLBACK  = 2'd1,
		REG_DUTY_FLOOR    = 2'd2,
		REG_DUTY_CEILING  = 2'd3
	} reg_idx_e;

	typedef struct packed {
		logic signed [15:0] ia;
		logic signed [15:0] ib;
		logic [15:0]        angle;
		logic signed [15:0] vd;
		logic signed [15:0] vq;
		logic [15:0]        bus;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] cur_d;
		logic signed [15:0] cur_q;
		logic [15:0]        da;
		logic [15:0]        db;
		logic [15:0]        dc;
	} duty_set_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic signed [15:0] phase_a_current;
	logic signed [15:0] phase_b_current;
	logic [15:0]        rotor_angle;
	logic signed [15:0] volt_d;
	logic signed [15:0] volt_q;
	logic [15:0]        bus_voltage;
	logic signed [15:0] current_d;
	logic signed [15:0] current_q;
	logic [15:0]        duty_a;
	logic [15:0]        duty_b;
	logic [15:0]        duty_c;

	foc_transform_svpwm_chain dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.phase_a_current(phase_a_current), .phase_b_current(phase_b_current),
		.rotor_angle(rotor_angle), .volt_d(volt_d), .volt_q(volt_q),
		.bus_voltage(bus_voltage), .current_d(current_d), .current_q(current_q),
		.duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c)
	);

	// shadow copy of the four registers, indexed by reg_idx_e
	logic [15:0] shadow_cfg [4];
	duty_set_t   pending_duties [$];
	int          errors;
	int          quiet_cycles;
	bit          no_idle;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// round half up by s bits; >>> on longint floors negative values
	function automatic longint round_down_half(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// scale one phase voltage by 1/bus, round half away from zero, recenter, clamp
	function automatic logic [15:0] scale_duty(longint u, longint bus);
		longint num, mag, q, d;
		num = u * 16384;
		mag = (num < 0) ? -num : num;
		q = (mag + bus / 2) / bus;
		d = ((num < 0) ? -q : q) + 32768;
		if (d > longint'(shadow_cfg[REG_DUTY_CEILING]))
			d = longint'(shadow_cfg[REG_DUTY_CEILING]);
		else if (d < longint'(shadow_cfg[REG_DUTY_FLOOR]))
			d = longint'(shadow_cfg[REG_DUTY_FLOOR]);
		return d[15:0];
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic duty_set_t predict_duties(sample_t s);
		logic [31:0] ang32, r;
		logic [1:0]  quad;
		longint      x, y, z, t, c30, s30, c, sn;
		longint      ia, ib, vd, vq, ibeta, va, vb, h, a2, b2, c2, mx, mn, bus;
		duty_set_t   o;
		ia = s.ia;
		ib = s.ib;
		vd = s.vd;
		vq = s.vq;
		ang32 = {s.angle, 16'h0000};
		quad = 2'((ang32 + 32'h2000_0000) >> 30);
		r = ang32 - ({30'd0, quad} << 30);
		z = longint'(signed'(r));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z < 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(ATAN_TURNS[i]);
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(ATAN_TURNS[i]);
			end
			x = t;
		end
		case (quad)
			2'd0: begin c30 = x;  s30 = y;  end
			2'd1: begin c30 = -y; s30 = x;  end
			2'd2: begin c30 = -x; s30 = -y; end
			default: begin c30 = y; s30 = -x; end
		endcase
		c = round_down_half(c30, 16);
		sn = round_down_half(s30, 16);

		ibeta = ((ia + 2 * ib) * 37837 + 32768) >>> 16;
		o.cur_d = 16'(clip16(round_down_half(ia * c + ibeta * sn, 14)));
		o.cur_q = 16'(clip16(round_down_half(ibeta * c - ia * sn, 14)));

		va = round_down_half(vd * c - vq * sn, 14);
		vb = round_down_half(vd * sn + vq * c, 14);
		h = (vb * 56756 + 32768) >>> 16;
		a2 = 2 * va;
		b2 = -va + 2 * h;
		c2 = -va - 2 * h;
		mx = a2;
		mn = a2;
		if (b2 > mx) mx = b2;
		if (b2 < mn) mn = b2;
		if (c2 > mx) mx = c2;
		if (c2 < mn) mn = c2;

		bus = (s.bus < shadow_cfg[REG_BUS_MIN_VALID]) ? longint'(shadow_cfg[REG_BUS_FALLBACK])
			: longint'(s.bus);
		if (bus == 0)
			bus = 1;
		o.da = scale_duty(2 * a2 - (mx + mn), bus);
		o.db = scale_duty(2 * b2 - (mx + mn), bus);
		o.dc = scale_duty(2 * c2 - (mx + mn), bus);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Checking: results cannot be held off, so take each one while done is high
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		duty_set_t want;
		if (arst_n && done) begin
			if (pending_duties.size() == 0) begin
				report_mismatch("done with no request outstanding", 16'd1, 16'd0);
			end else begin
				want = pending_duties.pop_front();
				if (current_d !== want.cur_d) report_mismatch("current_d", current_d, want.cur_d);
				if (current_q !== want.cur_q) report_mismatch("current_q", current_q, want.cur_q);
				if (duty_a !== want.da) report_mismatch("duty_a", duty_a, want.da);
				if (duty_b !== want.db) report_mismatch("duty_b", duty_b, want.db);
				if (duty_c !== want.dc) report_mismatch("duty_c", duty_c, want.dc);
			end
		end
	end

	// watchdog: trip when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// drop start; every later request raises it again in its own step
	task automatic hold_start_low();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// issue one request and log its prediction on the accepting edge
	task automatic send_sample(sample_t s);
		int gap;
		gap = 0;
		// idle each cycle with a chance of about 13 in 100
		while (!no_idle && $urandom_range(0, 99) < 13)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		phase_a_current <= s.ia;
		phase_b_current <= s.ib;
		rotor_angle <= s.angle;
		volt_d <= s.vd;
		volt_q <= s.vq;
		bus_voltage <= s.bus;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_duties.push_back(predict_duties(s));
	endtask

	// registers are read live by the pipeline: drain it before a write
	task automatic drain();
		hold_start_low();
		while (pending_duties.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_e idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cfg[idx] = val;
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		s.ia = 16'($urandom);
		s.ib = 16'($urandom);
		s.angle = 16'($urandom);
		// mostly realistic voltage commands, sometimes full range
		if ($urandom_range(0, 3) == 0) begin
			s.vd = 16'($urandom);
			s.vq = 16'($urandom);
		end else begin
			s.vd = 16'($urandom_range(0, 8191)) - 16'd4096;
			s.vq = 16'($urandom_range(0, 8191)) - 16'd4096;
		end
		case ($urandom_range(0, 5))
			0: s.bus = 16'($urandom_range(0, 400));
			1: s.bus = 16'($urandom);
			default: s.bus = 16'($urandom_range(2048, 16384));
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_extremes();
		sample_t s;
		logic [15:0] angles [6];
		angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
		for (int i = 0; i < 6; i++) begin
			s = '{16'sh7FFF, 16'sh7FFF, angles[i], 16'sh0400, 16'sh0200, 16'd6144};
			send_sample(s);
		end
		// most negative and mixed extreme currents and voltages
		send_sample('{16'sh8000, 16'sh8000, 16'h1234, 16'sh8000, 16'sh8000, 16'hFFFF});
		send_sample('{16'sh7FFF, 16'sh8000, 16'h6000, 16'sh7FFF, 16'sh7FFF, 16'd1});
		send_sample('{16'sh8000, 16'sh7FFF, 16'hA000, 16'sh7FFF, 16'sh8000, 16'd256});
		// invalid bus just below the minimum and exactly at it
		send_sample('{16'sh1000, 16'sh0800, 16'h3000, 16'sh0300, 16'sh0100, 16'd255});
		send_sample('{16'sh1000, 16'sh0800, 16'h3000, 16'sh0300, 16'sh0100, 16'd256});
		send_sample('{16'sh0000, 16'sh0000, 16'h0000, 16'sh0000, 16'sh0000, 16'd0});
		// zero effective bus: no minimum and a measured zero
		write_reg(REG_BUS_MIN_VALID, 16'd0);
		send_sample('{16'sh0100, 16'sh0000, 16'h0800, 16'sh0001, 16'sh0000, 16'd0});
		send_sample('{16'sh0000, 16'sh0100, 16'h5000, 16'shFFFF, 16'sh0002, 16'd0});
		// zero fallback with every bus invalid
		write_reg(REG_BUS_MIN_VALID, 16'hFFFF);
		write_reg(REG_BUS_FALLBACK, 16'd0);
		send_sample('{16'sh0100, 16'sh0000, 16'h0800, 16'sh0010, 16'sh0000, 16'd1000});
		// floor above ceiling
		write_reg(REG_BUS_FALLBACK, 16'd3072);
		write_reg(REG_DUTY_FLOOR, 16'd50000);
		write_reg(REG_DUTY_CEILING, 16'd20000);
		send_sample('{16'sh0100, 16'sh0200, 16'h7000, 16'sh0300, 16'sh0100, 16'd4000});
		send_sample('{16'sh0100, 16'sh0200, 16'h7000, 16'sh0000, 16'sh0000, 16'd4000});
		drain();
	endtask

	task automatic test_config_sweep();
		logic [15:0] settings [5][4];
		settings = '{
			'{16'd256, 16'd3072, 16'd3277, 16'd62259},
			'{16'd0, 16'd1, 16'd0, 16'hFFFF},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0},
			'{16'd1024, 16'd100, 16'd30000, 16'd35000},
			'{16'd512, 16'd12288, 16'd1000, 16'd64000}
		};
		for (int k = 0; k < 5; k++) begin
			write_reg(REG_BUS_MIN_VALID, settings[k][0]);
			write_reg(REG_BUS_FALLBACK, settings[k][1]);
			write_reg(REG_DUTY_FLOOR, settings[k][2]);
			write_reg(REG_DUTY_CEILING, settings[k][3]);
			repeat (30)
				send_sample(random_sample());
		end
		drain();
	endtask

	task automatic test_random_stream();
		write_reg(REG_BUS_MIN_VALID, 16'd256);
		write_reg(REG_BUS_FALLBACK, 16'd3072);
		write_reg(REG_DUTY_FLOOR, 16'd3277);
		write_reg(REG_DUTY_CEILING, 16'd62259);
		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 200 && n < 400);
			// pause once until the pipeline is empty
			if (n == 450)
				drain();
			send_sample(random_sample());
		end
		no_idle = 1'b0;
		hold_start_low();
	endtask

	initial begin
		int waited;
		errors = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		phase_a_current = '0;
		phase_b_current = '0;
		rotor_angle = '0;
		volt_d = '0;
		volt_q = '0;
		bus_voltage = '0;
		shadow_cfg = '{16'd256, 16'd3072, 16'd3277, 16'd62259};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_config_sweep();
		test_random_stream();

		// wait out the tail, then wait on for stray results
		waited = 0;
		while (pending_duties.size() != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0 && pending_duties.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
